[design/cod_pkg.sv]
// shared types and constants of the clock offset and drift tracker
// no dependencies; used by cod_alu and clock_offset_drift_tracker_core
package cod_pkg;

    localparam int WIDE_W    = 128;
    localparam int OPB_W     = 64;
    localparam int STEP_W    = 7;
    localparam logic [STEP_W-1:0] MUL_LAST = 7'd63;
    localparam logic [STEP_W-1:0] DIV_LAST = 7'd127;

    localparam logic [63:0] TERM_MAX  = 64'h4000_0000_0000_0000;
    localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [47:0] MASK48    = 48'hFFFF_FFFF_FFFF;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL,
        ST_MUL_WAIT,
        ST_TERM,
        ST_PRED,
        ST_ERR,
        ST_PUSH,
        ST_VAR_CHK,
        ST_VAR_RD,
        ST_VAR_LD,
        ST_VAR_WAIT,
        ST_VAR_ACC,
        ST_SQ,
        ST_SQ_WAIT,
        ST_NUM,
        ST_NUM_CHK,
        ST_DIV_WAIT,
        ST_POP,
        ST_DRIFT,
        ST_DRIFT_WAIT,
        ST_FINISH
    } state_t;

endpackage

[design/cod_ram.sv]
// generic simple dual port ram with registered read
// no dependencies
module cod_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[design/cod_alu.sv]
// iterative shift-add multiplier and restoring divider on one 65 bit adder
// depends on cod_pkg
module cod_alu (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cod_pkg::alu_ctrl_t            ctrl,
    input  logic [cod_pkg::WIDE_W-1:0]    opa,
    input  logic [cod_pkg::OPB_W-1:0]     opb,
    output logic [cod_pkg::WIDE_W-1:0]    result,
    output cod_pkg::alu_stat_t            stat
);

    logic                          busy_reg;
    logic                          done_reg;
    cod_pkg::alu_op_t              op_reg;
    logic [cod_pkg::STEP_W-1:0]    step_reg;
    logic [cod_pkg::OPB_W-1:0]     a_reg;
    logic [cod_pkg::OPB_W-1:0]     rem_reg;
    logic [cod_pkg::WIDE_W-1:0]    p_reg;

    logic [64:0] add_x;
    logic [64:0] add_y;
    logic        add_cin;
    logic [65:0] add_s;
    logic [cod_pkg::STEP_W-1:0] last_step;

    always_comb
    begin
        if (op_reg == cod_pkg::ALU_MUL)
        begin
            add_x   = {1'b0, p_reg[127:64]};
            add_y   = p_reg[0] ? {1'b0, a_reg} : 65'd0;
            add_cin = 1'b0;
        end
        else
        begin
            // remainder minus divisor, carry out means no borrow
            add_x   = {rem_reg, p_reg[127]};
            add_y   = ~{1'b0, a_reg};
            add_cin = 1'b1;
        end
        add_s     = {1'b0, add_x} + {1'b0, add_y} + {65'd0, add_cin};
        last_step = (op_reg == cod_pkg::ALU_MUL) ? cod_pkg::MUL_LAST : cod_pkg::DIV_LAST;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= cod_pkg::ALU_MUL;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= ctrl.op;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg <= '0;
            if (ctrl.op == cod_pkg::ALU_MUL)
            begin
                a_reg <= opa[63:0];
                p_reg <= {64'd0, opb};
            end
            else
            begin
                a_reg <= opb;
                p_reg <= opa;
            end
        end
        else if (busy_reg)
        begin
            if (op_reg == cod_pkg::ALU_MUL)
            begin
                p_reg <= {add_s[64:0], p_reg[63:1]};
            end
            else
            begin
                rem_reg <= add_s[65] ? add_s[63:0] : add_x[63:0];
                p_reg   <= {p_reg[126:0], add_s[65]};
            end
        end
    end

    assign result    = p_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[design/clock_offset_drift_tracker_core.sv]
// correct item: drift term multiply, prediction, then the result; the window is left as it is
// sync item: runs a variance pass over the n entries (2..WINDOW_SIZE) of the window fill after push;
// the pass is skipped with fewer than two entries; the variance or drift divide is skipped on a zero operand
// the shared alu does a 64 step multiply per window entry and for the squared sum, and 128 step divides
// one item at a time; a result waiting in the output register holds off the next item
// rst_n is asynchronous: clears model state, window fill and fallback (to 1)
module clock_offset_drift_tracker_core #(
    parameter int WINDOW_SIZE         = 16,
    parameter int DRIFT_FRACTION_BITS = 40
) (
    input  logic         clk,
    input  logic         rst_n,
    // configuration: fallback_variance
    input  logic         cfg_wr_en,
    input  logic [47:0]  cfg_wr_data,
    // input item
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // arrival_ticks[47:0], reference_ticks[95:48]
    input  logic         s_tuser,   // command
    // result item
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // corrected_ticks[48:0], error_variance[96:49], zero pad
    output logic [1:0]   m_tuser    // used_fallback[0], divide_fault[1]
);

    localparam int IDXW = $clog2(WINDOW_SIZE);
    localparam int CNTW = $clog2(WINDOW_SIZE + 1);
    localparam int SUMW = 49 + CNTW;
    localparam logic [127:0] HALF = 128'(1) << (DRIFT_FRACTION_BITS - 1);
    localparam logic [CNTW-1:0] WIN_FULL = CNTW'(WINDOW_SIZE);

    // window index arithmetic modulo the window size
    function automatic logic [IDXW-1:0] win_addr(input logic [IDXW-1:0] base,
                                                 input logic [CNTW-1:0] ofs);
        logic [CNTW:0] s;
        s = (CNTW+1)'(base) + (CNTW+1)'(ofs);
        if (s >= (CNTW+1)'(WINDOW_SIZE))
        begin
            s = s - (CNTW+1)'(WINDOW_SIZE);
        end
        return s[IDXW-1:0];
    endfunction

    function automatic logic [IDXW-1:0] win_inc(input logic [IDXW-1:0] h);
        return (h == IDXW'(WINDOW_SIZE - 1)) ? '0 : h + IDXW'(1);
    endfunction

    function automatic logic signed [48:0] clamp49(input logic signed [63:0] v);
        if (v > 64'sh0000_FFFF_FFFF_FFFF)
        begin
            return 49'sh0_FFFF_FFFF_FFFF;
        end
        if (v < -64'sh0001_0000_0000_0000)
        begin
            return 49'sh1_0000_0000_0000;
        end
        return v[48:0];
    endfunction

    cod_pkg::state_t state_reg, state_next;

    // item and model state
    logic                    cmd_reg;
    logic [47:0]             toa_reg;
    logic [47:0]             ref_reg;
    logic signed [48:0]      td_reg;     // arrival minus last sync time
    logic signed [63:0]      term_reg;
    logic signed [48:0]      pred_reg;
    logic signed [48:0]      err_reg;
    logic signed [48:0]      offset_reg;
    logic [47:0]             lst_reg;
    logic signed [48:0]      off_reg;
    logic [63:0]             drift_reg;
    logic [47:0]             fallback_reg;

    // window bookkeeping and variance accumulators
    logic [CNTW-1:0]         count_reg;
    logic [IDXW-1:0]         head_reg;
    logic [CNTW-1:0]         idx_reg;
    logic signed [SUMW-1:0]  sum_reg;
    logic [127:0]            nsq_reg;
    logic [47:0]             var_reg;
    logic                    ok_reg;
    logic                    fault_reg;

    // result register
    logic                    out_valid_reg;
    logic signed [48:0]      out_corr_reg;
    logic [47:0]             out_var_reg;
    logic                    out_fb_reg;
    logic                    out_fault_reg;

    // shared alu
    cod_pkg::alu_ctrl_t      alu_ctrl;
    cod_pkg::alu_stat_t      alu_stat;
    logic [127:0]            alu_opa;
    logic [63:0]             alu_opb;
    logic [127:0]            alu_res;

    // window memory
    logic                    ram_we;
    logic [IDXW-1:0]         ram_waddr;
    logic [IDXW-1:0]         ram_raddr;
    logic [48:0]             ram_rdata;

    // datapath terms
    logic [48:0]             td_neg;
    logic [47:0]             td_abs;
    logic [63:0]             dmag;
    logic [127:0]            p_round;
    logic [127:0]            p_shift;
    logic [63:0]             term_mag;
    logic signed [63:0]      term_val;
    logic signed [63:0]      pred_full;
    logic signed [63:0]      err_full;
    logic signed [48:0]      offset_val;
    logic signed [49:0]      dnum;
    logic [49:0]             dnum_neg;
    logic [49:0]             dnum_abs;
    logic [63:0]             drift_mag;
    logic [63:0]             drift_val;
    logic signed [48:0]      win_d;
    logic [48:0]             win_neg;
    logic [48:0]             win_abs;
    logic [48+CNTW:0]        win_scaled;
    logic [SUMW-1:0]         sum_neg;
    logic [SUMW-1:0]         sum_abs;
    logic [2*CNTW-1:0]       nn1;
    logic [47:0]             var_sat;
    logic                    win_full;
    logic [IDXW-1:0]         head_p;
    logic [CNTW-1:0]         count_p;
    logic                    out_free;

    cod_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (alu_ctrl),
        .opa    (alu_opa),
        .opb    (alu_opb),
        .result (alu_res),
        .stat   (alu_stat)
    );

    cod_ram #(
        .WIDTH (49),
        .DEPTH (WINDOW_SIZE)
    ) u_window (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (err_reg),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign s_tready = (state_reg == cod_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        // extrapolation: |drift| * |td|, rounded, saturated at 2^62
        td_neg    = 49'd0 - td_reg;
        td_abs    = td_reg[48] ? td_neg[47:0] : td_reg[47:0];
        dmag      = drift_reg[63] ? 64'd0 - drift_reg : drift_reg;
        p_round   = alu_res + HALF;
        p_shift   = p_round >> DRIFT_FRACTION_BITS;
        term_mag  = (p_shift > {64'd0, cod_pkg::TERM_MAX}) ? cod_pkg::TERM_MAX
                                                           : p_shift[63:0];
        term_val  = (drift_reg[63] != td_reg[48]) ? -$signed(term_mag) : $signed(term_mag);
        pred_full = $signed({16'd0, toa_reg})
                  - ($signed({{15{off_reg[48]}}, off_reg}) + term_reg);
        err_full  = $signed({{15{pred_reg[48]}}, pred_reg}) - $signed({16'd0, ref_reg});
        offset_val = $signed({1'b0, toa_reg}) - $signed({1'b0, ref_reg});

        // drift numerator and saturated quotient
        dnum      = $signed({offset_reg[48], offset_reg}) - $signed({off_reg[48], off_reg});
        dnum_neg  = 50'd0 - dnum;
        dnum_abs  = dnum[49] ? dnum_neg : dnum;
        drift_mag = (alu_res > {64'd0, cod_pkg::INT64_MAX}) ? cod_pkg::INT64_MAX
                                                           : alu_res[63:0];
        drift_val = (dnum[49] != td_reg[48]) ? 64'd0 - drift_mag : drift_mag;

        // window entry terms
        win_d      = ram_rdata;
        win_neg    = 49'd0 - win_d;
        win_abs    = win_d[48] ? win_neg : win_d;
        win_scaled = win_abs * count_reg;
        sum_neg    = SUMW'(0) - sum_reg;
        sum_abs    = sum_reg[SUMW-1] ? sum_neg : sum_reg;
        nn1        = count_reg * (count_reg - CNTW'(1));
        var_sat    = (alu_res > {80'd0, cod_pkg::MASK48}) ? cod_pkg::MASK48 : alu_res[47:0];

        // drop the oldest entry when full
        win_full = (count_reg >= WIN_FULL);
        head_p   = win_full ? win_inc(head_reg) : head_reg;
        count_p  = win_full ? count_reg - CNTW'(1) : count_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cod_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = cod_pkg::ST_MUL;
                end
            end
            cod_pkg::ST_MUL:       state_next = cod_pkg::ST_MUL_WAIT;
            cod_pkg::ST_MUL_WAIT:
            begin
                if (alu_stat.done)
                begin
                    state_next = cod_pkg::ST_TERM;
                end
            end
            cod_pkg::ST_TERM:      state_next = cod_pkg::ST_PRED;
            cod_pkg::ST_PRED:
            begin
                state_next = cmd_reg ? cod_pkg::ST_FINISH : cod_pkg::ST_ERR;
            end
            cod_pkg::ST_ERR:       state_next = cod_pkg::ST_PUSH;
            cod_pkg::ST_PUSH:      state_next = cod_pkg::ST_VAR_CHK;
            cod_pkg::ST_VAR_CHK:
            begin
                state_next = (count_reg < CNTW'(2)) ? cod_pkg::ST_POP : cod_pkg::ST_VAR_RD;
            end
            cod_pkg::ST_VAR_RD:    state_next = cod_pkg::ST_VAR_LD;
            cod_pkg::ST_VAR_LD:    state_next = cod_pkg::ST_VAR_WAIT;
            cod_pkg::ST_VAR_WAIT:
            begin
                if (alu_stat.done)
                begin
                    state_next = cod_pkg::ST_VAR_ACC;
                end
            end
            cod_pkg::ST_VAR_ACC:
            begin
                state_next = (idx_reg + CNTW'(1) == count_reg) ? cod_pkg::ST_SQ
                                                               : cod_pkg::ST_VAR_RD;
            end
            cod_pkg::ST_SQ:        state_next = cod_pkg::ST_SQ_WAIT;
            cod_pkg::ST_SQ_WAIT:
            begin
                if (alu_stat.done)
                begin
                    state_next = cod_pkg::ST_NUM;
                end
            end
            cod_pkg::ST_NUM:       state_next = cod_pkg::ST_NUM_CHK;
            cod_pkg::ST_NUM_CHK:
            begin
                state_next = (nsq_reg == 128'd0) ? cod_pkg::ST_POP : cod_pkg::ST_DIV_WAIT;
            end
            cod_pkg::ST_DIV_WAIT:
            begin
                if (alu_stat.done)
                begin
                    state_next = cod_pkg::ST_POP;
                end
            end
            cod_pkg::ST_POP:       state_next = cod_pkg::ST_DRIFT;
            cod_pkg::ST_DRIFT:
            begin
                state_next = (td_reg == 49'sd0) ? cod_pkg::ST_FINISH : cod_pkg::ST_DRIFT_WAIT;
            end
            cod_pkg::ST_DRIFT_WAIT:
            begin
                if (alu_stat.done)
                begin
                    state_next = cod_pkg::ST_FINISH;
                end
            end
            cod_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = cod_pkg::ST_IDLE;
                end
            end
            default:               state_next = cod_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: alu start and operands, window ports
    always_comb
    begin
        alu_ctrl.start = 1'b0;
        alu_ctrl.op    = cod_pkg::ALU_MUL;
        alu_opa        = {64'd0, dmag};
        alu_opb        = {16'd0, td_abs};
        ram_we         = 1'b0;
        ram_waddr      = win_addr(head_p, count_p);
        ram_raddr      = win_addr(head_reg, idx_reg);
        unique case (state_reg)
            cod_pkg::ST_MUL:
            begin
                alu_ctrl.start = 1'b1;
            end
            cod_pkg::ST_PUSH:
            begin
                ram_we = (err_reg != 49'sd0);
            end
            cod_pkg::ST_VAR_LD:
            begin
                // n * d * d as (n * |d|) * |d|
                alu_ctrl.start = 1'b1;
                alu_opa        = 128'(win_scaled);
                alu_opb        = 64'(win_abs);
            end
            cod_pkg::ST_SQ:
            begin
                alu_ctrl.start = 1'b1;
                alu_opa        = 128'(sum_abs);
                alu_opb        = 64'(sum_abs);
            end
            cod_pkg::ST_NUM_CHK:
            begin
                alu_ctrl.start = (nsq_reg != 128'd0);
                alu_ctrl.op    = cod_pkg::ALU_DIV;
                alu_opa        = nsq_reg;
                alu_opb        = 64'(nn1);
            end
            cod_pkg::ST_DRIFT:
            begin
                alu_ctrl.start = (td_reg != 49'sd0);
                alu_ctrl.op    = cod_pkg::ALU_DIV;
                alu_opa        = 128'(dnum_abs) << DRIFT_FRACTION_BITS;
                alu_opb        = {16'd0, td_abs};
            end
            default:
            begin
                alu_ctrl.start = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cod_pkg::ST_IDLE;
            lst_reg       <= '0;
            off_reg       <= '0;
            drift_reg     <= '0;
            fallback_reg  <= 48'd1;
            count_reg     <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                fallback_reg <= cfg_wr_data;
            end
            // the finishing step reloads the result register itself
            if (m_tready && state_reg != cod_pkg::ST_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                cod_pkg::ST_PUSH:
                begin
                    if (err_reg != 49'sd0)
                    begin
                        head_reg  <= head_p;
                        count_reg <= count_p + CNTW'(1);
                    end
                end
                cod_pkg::ST_POP:
                begin
                    head_reg  <= head_p;
                    count_reg <= count_p;
                end
                cod_pkg::ST_DRIFT_WAIT:
                begin
                    if (alu_stat.done)
                    begin
                        drift_reg <= drift_val;
                    end
                end
                cod_pkg::ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (!cmd_reg)
                        begin
                            lst_reg <= toa_reg;
                            off_reg <= offset_reg;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            cod_pkg::ST_IDLE:
            begin
                cmd_reg <= s_tuser;
                toa_reg <= s_tdata[47:0];
                ref_reg <= s_tdata[95:48];
                td_reg  <= $signed({1'b0, s_tdata[47:0]}) - $signed({1'b0, lst_reg});
            end
            cod_pkg::ST_TERM:
            begin
                term_reg <= term_val;
            end
            cod_pkg::ST_PRED:
            begin
                pred_reg <= clamp49(pred_full);
            end
            cod_pkg::ST_ERR:
            begin
                err_reg    <= clamp49(err_full);
                offset_reg <= offset_val;
            end
            cod_pkg::ST_PUSH:
            begin
                ok_reg    <= 1'b0;
                fault_reg <= 1'b0;
                sum_reg   <= '0;
                nsq_reg   <= '0;
                idx_reg   <= '0;
            end
            cod_pkg::ST_VAR_LD:
            begin
                sum_reg <= sum_reg + SUMW'(win_d);
            end
            cod_pkg::ST_VAR_ACC:
            begin
                nsq_reg <= nsq_reg + alu_res;
                idx_reg <= idx_reg + CNTW'(1);
            end
            cod_pkg::ST_NUM:
            begin
                nsq_reg <= nsq_reg - alu_res;
            end
            cod_pkg::ST_DIV_WAIT:
            begin
                if (alu_stat.done)
                begin
                    var_reg <= var_sat;
                    ok_reg  <= 1'b1;
                end
            end
            cod_pkg::ST_DRIFT:
            begin
                fault_reg <= (td_reg == 49'sd0);
            end
            cod_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_corr_reg  <= cmd_reg ? pred_reg : 49'sd0;
                    out_var_reg   <= cmd_reg ? 48'd0 : (ok_reg ? var_reg : fallback_reg);
                    out_fb_reg    <= !cmd_reg && !ok_reg;
                    out_fault_reg <= !cmd_reg && fault_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_var_reg, out_corr_reg};
    assign m_tuser  = {out_fault_reg, out_fb_reg};

`ifndef SYNTHESIS
    // between items the window never holds a full set
    a_window_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cod_pkg::ST_IDLE) |-> (count_reg < WIN_FULL))
        else $error("window full while idle");

    // the shared unit is never restarted while it iterates
    a_alu_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        alu_ctrl.start |-> !alu_stat.busy)
        else $error("alu started while busy");

    // no new item is taken while the shared unit still works
    a_ready_alu_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !alu_stat.busy)
        else $error("ready while alu busy");

    // a result appears only from the finishing step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == cod_pkg::ST_FINISH))
        else $error("result without finishing step");
`endif

endmodule
